@@ sv/apu_pkg.sv @@
// shared constants, types and rounding helper for the adam update pipeline
package apu_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_STEPS      = 40;
  localparam int DIV_LAT        = DIV_STEPS + 2;
  localparam int MAG_W          = 44;
  localparam int NUM_W          = 76;
  localparam int DEN_W          = 43;
  localparam int Q_W            = DIV_STEPS + 1;
  localparam int ADDR_W         = 5;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  localparam logic [2:0] REG_LR    = 3'd0;
  localparam logic [2:0] REG_BETA1 = 3'd1;
  localparam logic [2:0] REG_BETA2 = 3'd2;
  localparam logic [2:0] REG_EPS   = 3'd3;
  localparam logic [2:0] REG_IBC1  = 3'd4;
  localparam logic [2:0] REG_IBC2  = 3'd5;

  localparam logic [31:0] LR_RST    = 32'd4294967;
  localparam logic [31:0] BETA1_RST = 32'd1932735283;
  localparam logic [31:0] BETA2_RST = 32'd2145336164;
  localparam logic [31:0] EPS_RST   = 32'd43;
  localparam logic [31:0] IBC_RST   = 32'd1048576;

  // values that ride alongside the long arithmetic units
  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] m;
    logic [31:0]        v;
    logic               neg;
  } side_t;

  // shift right with rounding of the magnitude, halves away from zero
  function automatic logic signed [63:0] round_mag(input logic signed [63:0] x,
                                                   input int unsigned s);
    logic [63:0] half;
    logic [63:0] mag;
    logic [63:0] r;
    half = 64'd1 << (s - 1);
    if (x < 0) begin
      mag = 64'(-x);
      r   = (mag + half) >> s;
      return -$signed(r);
    end else begin
      r = (64'(x) + half) >> s;
      return $signed(r);
    end
  endfunction

endpackage

@@ sv/apu_sqrt.sv @@
// pipelined integer square root, two radicand bits per stage
module apu_sqrt import apu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] radicand,
  output logic        out_valid,
  output logic [31:0] root
);

  logic        vld [SQRT_STEPS];
  logic [33:0] rem [SQRT_STEPS];
  logic [31:0] rt  [SQRT_STEPS];
  logic [63:0] xs  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    logic        vld_prev;
    logic [33:0] rem_prev;
    logic [31:0] rt_prev;
    logic [63:0] xs_prev;
    logic [35:0] trial_rem;
    logic [35:0] trial_sub;

    if (k == 0) begin : g_first
      assign vld_prev = in_valid;
      assign rem_prev = '0;
      assign rt_prev  = '0;
      assign xs_prev  = radicand;
    end else begin : g_next
      assign vld_prev = vld[k-1];
      assign rem_prev = rem[k-1];
      assign rt_prev  = rt[k-1];
      assign xs_prev  = xs[k-1];
    end

    assign trial_rem = {rem_prev, xs_prev[63:62]};
    assign trial_sub = {2'b00, rt_prev, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k] <= {xs_prev[61:0], 2'b00};
        if (trial_rem >= trial_sub) begin
          rem[k] <= 34'(trial_rem - trial_sub);
          rt[k]  <= {rt_prev[30:0], 1'b1};
        end else begin
          rem[k] <= trial_rem[33:0];
          rt[k]  <= {rt_prev[30:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS-1];
  assign root      = rt[SQRT_STEPS-1];

endmodule

@@ sv/apu_div.sv @@
// pipelined restoring divider, rounded quotient capped at 2^40
module apu_div import apu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_valid,
  output logic [Q_W-1:0]   quo
);

  localparam logic [Q_W-1:0] CAP = Q_W'(1) << DIV_STEPS;

  // entry stage: overflow and zero-denominator detection
  logic                 p_vld;
  logic [DEN_W-1:0]     p_rem;
  logic [DIV_STEPS-1:0] p_low;
  logic [DEN_W-1:0]     p_den;
  logic                 p_cap;
  logic                 p_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rem  <= DEN_W'(num[NUM_W-1:DIV_STEPS]);
      p_low  <= num[DIV_STEPS-1:0];
      p_den  <= den;
      p_zero <= (den == '0) && (num == '0);
      p_cap  <= (den == '0) ? (num != '0) : (DEN_W'(num[NUM_W-1:DIV_STEPS]) >= den);
    end
  end

  logic                 vld  [DIV_STEPS];
  logic [DEN_W-1:0]     rem  [DIV_STEPS];
  logic [DIV_STEPS-1:0] low  [DIV_STEPS];
  logic [DIV_STEPS-1:0] qt   [DIV_STEPS];
  logic [DEN_W-1:0]     dv   [DIV_STEPS];
  logic                 cap  [DIV_STEPS];
  logic                 zero [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    logic                 vld_prev;
    logic [DEN_W-1:0]     rem_prev;
    logic [DIV_STEPS-1:0] low_prev;
    logic [DIV_STEPS-1:0] qt_prev;
    logic [DEN_W-1:0]     dv_prev;
    logic                 cap_prev;
    logic                 zero_prev;
    logic [DEN_W:0]       trial;

    if (k == 0) begin : g_first
      assign vld_prev  = p_vld;
      assign rem_prev  = p_rem;
      assign low_prev  = p_low;
      assign qt_prev   = '0;
      assign dv_prev   = p_den;
      assign cap_prev  = p_cap;
      assign zero_prev = p_zero;
    end else begin : g_next
      assign vld_prev  = vld[k-1];
      assign rem_prev  = rem[k-1];
      assign low_prev  = low[k-1];
      assign qt_prev   = qt[k-1];
      assign dv_prev   = dv[k-1];
      assign cap_prev  = cap[k-1];
      assign zero_prev = zero[k-1];
    end

    assign trial = {rem_prev, low_prev[DIV_STEPS-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        low[k]  <= {low_prev[DIV_STEPS-2:0], 1'b0};
        dv[k]   <= dv_prev;
        cap[k]  <= cap_prev;
        zero[k] <= zero_prev;
        if (trial >= {1'b0, dv_prev}) begin
          rem[k] <= DEN_W'(trial - {1'b0, dv_prev});
          qt[k]  <= {qt_prev[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem[k] <= trial[DEN_W-1:0];
          qt[k]  <= {qt_prev[DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  // round to nearest from the final remainder
  logic f_vld;
  logic [Q_W-1:0] f_quo;
  logic round_up;

  assign round_up = {rem[DIV_STEPS-1], 1'b0} >= {1'b0, dv[DIV_STEPS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= vld[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero[DIV_STEPS-1]) begin
        f_quo <= '0;
      end else if (cap[DIV_STEPS-1]) begin
        f_quo <= CAP;
      end else begin
        f_quo <= Q_W'(qt[DIV_STEPS-1]) + Q_W'(round_up);
      end
    end
  end

  assign out_valid = f_vld;
  assign quo       = f_quo;

endmodule

@@ sv/adam_parameter_update_core.sv @@
// Adam parameter update: one weight/gradient/moment transaction accepted per clock, fully
// pipelined. Its stages: six of moment blending, bias correction and numerator products,
// a 32-stage square root (two radicand bits per stage), one adding epsilon, a 42-stage
// divider (one quotient bit per stage plus entry and rounding) and the output register.
// When out_ready low holds a result the whole pipeline freezes and in_ready drops; no
// transaction is lost or repeated. Registers sit on an APB port at byte address 4*index;
// the host must write them only while the pipeline is empty; the block does not check it.
module adam_parameter_update_core import apu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [31:0] weight_in,
  input  logic signed [31:0] gradient,
  input  logic signed [31:0] first_moment_in,
  input  logic [31:0]       second_moment_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [31:0] weight_out,
  output logic signed [31:0] first_moment_out,
  output logic [31:0]       second_moment_out
);

  localparam int SAT_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
  localparam logic [40:0] VMAX = (41'd1 << SAT_W) - 41'd1;

  function automatic logic signed [31:0] sat_s(input logic signed [63:0] x);
    if (x > SMAX) begin
      return SMAX[31:0];
    end else if (x < SMIN) begin
      return SMIN[31:0];
    end else begin
      return x[31:0];
    end
  endfunction

  // configuration registers
  logic [31:0] learning_rate;
  logic [31:0] beta_first;
  logic [31:0] beta_second;
  logic [31:0] epsilon;
  logic [31:0] inv_bias_corr_first;
  logic [31:0] inv_bias_corr_second;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate        <= LR_RST;
      beta_first           <= BETA1_RST;
      beta_second          <= BETA2_RST;
      epsilon              <= EPS_RST;
      inv_bias_corr_first  <= IBC_RST;
      inv_bias_corr_second <= IBC_RST;
    end else if (cfg_wr) begin
      unique case (paddr[ADDR_W-1:2])
        REG_LR:    learning_rate        <= pwdata;
        REG_BETA1: beta_first           <= pwdata;
        REG_BETA2: beta_second          <= pwdata;
        REG_EPS:   epsilon              <= pwdata;
        REG_IBC1:  inv_bias_corr_first  <= pwdata;
        REG_IBC2:  inv_bias_corr_second <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_LR:    prdata = learning_rate;
      REG_BETA1: prdata = beta_first;
      REG_BETA2: prdata = beta_second;
      REG_EPS:   prdata = epsilon;
      REG_IBC1:  prdata = inv_bias_corr_first;
      REG_IBC2:  prdata = inv_bias_corr_second;
      default:   prdata = '0;
    endcase
  end

  // betas above one act as one
  logic [31:0] b1;
  logic [31:0] b2;
  logic [31:0] c1;
  logic [31:0] c2;
  assign b1 = (beta_first > ONE_Q31) ? ONE_Q31 : beta_first;
  assign b2 = (beta_second > ONE_Q31) ? ONE_Q31 : beta_second;
  assign c1 = ONE_Q31 - b1;
  assign c2 = ONE_Q31 - b2;

  logic o_vld;
  logic adv;
  assign adv      = !o_vld || out_ready;
  assign in_ready = adv;

  // stage 1: moment products and gradient square
  logic               s1_vld;
  logic signed [64:0] s1_pm;
  logic signed [64:0] s1_pg;
  logic [63:0]        s1_gsq;
  logic [63:0]        s1_bv;
  logic signed [31:0] s1_w;
  logic [31:0]        gmag;

  assign gmag = gradient[31] ? 32'(-gradient) : 32'(gradient);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pm  <= $signed({1'b0, b1}) * first_moment_in;
      s1_pg  <= $signed({1'b0, c1}) * gradient;
      s1_gsq <= 64'(gmag) * 64'(gmag);
      s1_bv  <= 64'(b2) * 64'(second_moment_in);
      s1_w   <= weight_in;
    end
  end

  // stage 2: new first moment, rounded g^2, decayed second moment
  logic               s2_vld;
  logic signed [31:0] s2_m;
  logic [38:0]        s2_g2;
  logic [32:0]        s2_vp;
  logic signed [31:0] s2_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_m  <= sat_s(round_mag(64'(s1_pm) + 64'(s1_pg), 31));
      s2_g2 <= 39'((s1_gsq + 64'h80_0000) >> 24);
      s2_vp <= 33'((s1_bv + 64'h4000_0000) >> 31);
      s2_w  <= s1_w;
    end
  end

  // stage 3: (1-beta2)*g^2 split in two partial products, m' times correction
  logic               s3_vld;
  logic [63:0]        s3_lo;
  logic [38:0]        s3_hi;
  logic signed [64:0] s3_mp;
  logic signed [31:0] s3_m;
  logic [32:0]        s3_vp;
  logic signed [31:0] s3_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_lo <= 64'(c2) * 64'(s2_g2[31:0]);
      s3_hi <= 39'(c2) * 39'(s2_g2[38:32]);
      s3_mp <= $signed({1'b0, inv_bias_corr_first}) * s2_m;
      s3_m  <= s2_m;
      s3_vp <= s2_vp;
      s3_w  <= s2_w;
    end
  end

  // stage 4: new second moment, m_hat sign and magnitude
  logic               s4_vld;
  logic [31:0]        s4_v;
  logic [MAG_W-1:0]   s4_mag;
  logic               s4_neg;
  logic signed [31:0] s4_m;
  logic signed [31:0] s4_w;
  logic [40:0]        vn_wide;
  logic signed [63:0] mh;

  assign vn_wide = 41'(s3_vp) + 41'({s3_hi, 1'b0}) + 41'((s3_lo + 64'h4000_0000) >> 31);
  assign mh      = round_mag(64'(s3_mp), 20);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_v   <= (vn_wide > VMAX) ? VMAX[31:0] : vn_wide[31:0];
      s4_neg <= mh < 0;
      s4_mag <= MAG_W'((mh < 0) ? -mh : mh);
      s4_m   <= s3_m;
      s4_w   <= s3_w;
    end
  end

  // stage 5: v' times correction, learning rate times |m_hat| in two parts
  logic             s5_vld;
  logic [63:0]      s5_vv;
  logic [63:0]      s5_nlo;
  logic [MAG_W-1:0] s5_nhi;
  side_t            s5_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_vv   <= 64'(s4_v) * 64'(inv_bias_corr_second);
      s5_nlo  <= 64'(learning_rate) * 64'(s4_mag[31:0]);
      s5_nhi  <= MAG_W'(learning_rate) * MAG_W'(s4_mag[MAG_W-1:32]);
      s5_side <= '{w: s4_w, m: s4_m, v: s4_v, neg: s4_neg};
    end
  end

  // stage 6: v_hat as radicand, full numerator
  logic             s6_vld;
  logic [63:0]      s6_rad;
  logic [NUM_W-1:0] s6_num;
  side_t            s6_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_rad  <= {44'((s5_vv + 64'h8_0000) >> 20), 20'd0};
      s6_num  <= NUM_W'(s5_nlo) + {s5_nhi, 32'd0};
      s6_side <= s5_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
    end
  end

  // square root, with side values and numerator delayed alongside
  logic             sq_vld;
  logic [31:0]      sq_root;
  side_t            sq_side [SQRT_STEPS];
  logic [NUM_W-1:0] sq_num  [SQRT_STEPS];

  apu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s6_vld),
    .radicand  (s6_rad),
    .out_valid (sq_vld),
    .root      (sq_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side[0] <= s6_side;
      sq_num[0]  <= s6_num;
      for (int i = 1; i < SQRT_STEPS; i++) begin
        sq_side[i] <= sq_side[i-1];
        sq_num[i]  <= sq_num[i-1];
      end
    end
  end

  // denominator: root in Q.32 plus epsilon
  logic             dn_vld;
  logic [DEN_W-1:0] dn_den;
  logic [NUM_W-1:0] dn_num;
  side_t            dn_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else if (adv) begin
      dn_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_den  <= DEN_W'({sq_root, 10'd0}) + DEN_W'(epsilon);
      dn_num  <= sq_num[SQRT_STEPS-1];
      dn_side <= sq_side[SQRT_STEPS-1];
    end
  end

  // division
  logic           dv_vld;
  logic [Q_W-1:0] dv_quo;
  side_t          dv_side [DIV_LAT];

  apu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (dn_vld),
    .num       (dn_num),
    .den       (dn_den),
    .out_valid (dv_vld),
    .quo       (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side[0] <= dn_side;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv_side[i] <= dv_side[i-1];
      end
    end
  end

  // output register: weight step against the sign of m_hat
  side_t              last;
  logic signed [63:0] w_sum;

  assign last  = dv_side[DIV_LAT-1];
  assign w_sum = last.neg ? (64'(last.w) + $signed(64'(dv_quo)))
                          : (64'(last.w) - $signed(64'(dv_quo)));

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      weight_out        <= sat_s(w_sum);
      first_moment_out  <= last.m;
      second_moment_out <= last.v;
    end
  end

  assign out_valid = o_vld;

endmodule

@@ sv/apu_checker.sv @@
// port-level checks for the adam update core, bound to the top level
module apu_checker import apu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [31:0] weight_out,
  input logic [31:0]       second_moment_out
);

  localparam int SAT_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;

  // pipeline freezes exactly when a result is held
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stall");

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight_out))
    else $error("held result changed");

  a_second_moment_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (64'(second_moment_out) >> SAT_W) == 64'd0)
    else $error("second moment beyond saturation width");

endmodule

bind adam_parameter_update_core apu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_apu_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .weight_out        (weight_out),
  .second_moment_out (second_moment_out)
);

@@ bench/adam_parameter_update_core_tb.sv @@
// self-checking testbench for the adam parameter update core
`timescale 1ns / 1ps

module adam_parameter_update_core_tb;
  import apu_pkg::*;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_ITEMS = 242;

  typedef struct {
    logic signed [31:0] weight;
    logic signed [31:0] first_moment;
    logic [31:0]        second_moment;
  } adam_result_t;

  class adam_scoreboard;
    logic [31:0] lr, beta1, beta2, eps, ibc1, ibc2;
    adam_result_t expected_q[$];
    int errors;

    function new();
      lr = LR_RST;
      beta1 = BETA1_RST;
      beta2 = BETA2_RST;
      eps = EPS_RST;
      ibc1 = IBC_RST;
      ibc2 = IBC_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_LR: lr = val;
        REG_BETA1: beta1 = val;
        REG_BETA2: beta2 = val;
        REG_EPS: eps = val;
        REG_IBC1: ibc1 = val;
        REG_IBC2: ibc2 = val;
        default: ;
      endcase
    endfunction

    function logic signed [127:0] round_away(logic signed [127:0] x, int s);
      logic signed [127:0] half;
      half = 128'sd1 <<< (s - 1);
      if (x >= 0) return (x + half) >>> s;
      return -(((-x) + half) >>> s);
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic signed [127:0] sat32(logic signed [127:0] x);
      if (x > 128'sd2147483647) return 128'sd2147483647;
      if (x < -128'sd2147483648) return -128'sd2147483648;
      return x;
    endfunction

    function void note_input(logic [31:0] wi, logic [31:0] gi, logic [31:0] mi,
                             logic [31:0] vi);
      logic signed [127:0] w, g, m, b1s, c1s, ib1, mn, mh, wn;
      logic [127:0] b2, gm, g2, vn, den, mag, q, prod, rem;
      logic [63:0] tmp, rad;
      adam_result_t r;
      w = $signed(wi);
      g = $signed(gi);
      m = $signed(mi);
      b1s = (beta1 > ONE_Q31) ? 128'sd2147483648 : $signed({96'd0, beta1});
      c1s = 128'sd2147483648 - b1s;
      b2 = (beta2 > ONE_Q31) ? 128'd2147483648 : {96'd0, beta2};
      mn = sat32(round_away(b1s * m + c1s * g, 31));
      gm = (g < 0) ? -g : g;
      g2 = (gm * gm + (128'd1 << 23)) >> 24;
      vn = ((b2 * vi + (128'd1 << 30)) >> 31)
         + (((128'd2147483648 - b2) * g2 + (128'd1 << 30)) >> 31);
      if (vn > 128'hFFFF_FFFF) vn = 128'hFFFF_FFFF;
      ib1 = $signed({96'd0, ibc1});
      mh = round_away(mn * ib1, 20);
      // 64-bit wraparound matches the intended datapath widths
      tmp = 64'(vn * ibc2 + (128'd1 << 19));
      rad = (tmp >> 20) << 20;
      den = ({64'd0, floor_sqrt(rad)} << 10) + eps;
      mag = (mh < 0) ? -mh : mh;
      if (den == 0) begin
        q = (lr != 0 && mag != 0) ? (128'd1 << 40) : 0;
      end else begin
        prod = lr * mag;
        q = prod / den;
        rem = prod % den;
        if (q < (128'd1 << 40) && rem * 2 >= den) q = q + 1;
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
      end
      wn = sat32((mh < 0) ? w + $signed(q) : w - $signed(q));
      r.weight = wn[31:0];
      r.first_moment = mn[31:0];
      r.second_moment = vn[31:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] wo, logic [31:0] mo, logic [31:0] vo);
      adam_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result w %h m %h v %h", $time, wo, mo, vo);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (e.weight !== wo) begin
        $display("%0t weight_out expected %h actual %h", $time, e.weight, wo);
        errors++;
      end
      if (e.first_moment !== mo) begin
        $display("%0t first_moment_out expected %h actual %h", $time, e.first_moment, mo);
        errors++;
      end
      if (e.second_moment !== vo) begin
        $display("%0t second_moment_out expected %h actual %h", $time, e.second_moment, vo);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic signed [31:0] weight_in = '0, gradient = '0, first_moment_in = '0;
  logic [31:0] second_moment_in = '0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] weight_out, first_moment_out;
  logic [31:0] second_moment_out;

  adam_scoreboard sb = new();
  bit quiet = 0;
  int stall_cycles = 0;

  adam_parameter_update_core uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // results are checked mid-cycle, ahead of the edge that accepts them
  always @(negedge clk) begin
    if (out_valid && out_ready) sb.check_result(weight_out, first_moment_out, second_moment_out);
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("adam_parameter_update_core verification failed");
      $finish;
    end
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ready <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_update(logic [31:0] w, logic [31:0] g, logic [31:0] m, logic [31:0] v);
    bit taken;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1;
    weight_in <= w;
    gradient <= g;
    first_moment_in <= m;
    second_moment_in <= v;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sb.note_input(w, g, m, v);
  endtask

  task automatic wait_idle();
    // drop valid at the edge that took the last transaction
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(bit is_signed);
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h0;
          1: return 32'h1;
          2: return 32'hFFFF_FFFF;
          3: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: begin
        // typical training magnitudes
        if (is_signed && $urandom_range(0, 1)) return -$urandom_range(0, 32'h0100_0000);
        return $urandom_range(0, 32'h0100_0000);
      end
    endcase
  endfunction

  task automatic set_all(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                         logic [31:0] d, logic [31:0] e, logic [31:0] f);
    apb_write(REG_LR, a);
    apb_write(REG_BETA1, b);
    apb_write(REG_BETA2, c);
    apb_write(REG_EPS, d);
    apb_write(REG_IBC1, e);
    apb_write(REG_IBC2, f);
  endtask

  initial begin
    logic [31:0] dw[5];
    rst <= 1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed corners under the reset settings
    dw = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    send_update(32'h0, 32'h0, 32'h0, 32'h0);
    send_update(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_update(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_update(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_update(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_update(32'h0100_0000, 32'h0001_0000, 32'h0, 32'h0);
    for (int i = 0; i < 5; i++) send_update(dw[i], dw[(i + 1) % 5], dw[(i + 2) % 5], dw[(i + 3) % 5]);
    wait_idle();

    // zero denominator, weight saturates against the moment, or stays when the moment is zero
    set_all(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_update(32'h0, 32'h0100_0000, 32'h0, 32'h0);
    send_update(32'h0, 32'hFF00_0000, 32'h0, 32'h0);
    send_update(32'h1234_5678, 32'h0, 32'h0, 32'h0);
    wait_idle();
    // betas above one, zero learning rate and reciprocals
    set_all(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    apb_write(REG_SPARE_A, $urandom);
    apb_write(REG_SPARE_B, $urandom);
    send_update(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
    send_update(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_all(LR_RST, BETA1_RST, BETA2_RST, EPS_RST, 32'd10485760,
                   $urandom_range(32'h0010_0000, 32'h4000_0000));
        1: set_all($urandom, $urandom_range(0, ONE_Q31), $urandom_range(0, ONE_Q31), $urandom,
                   $urandom_range(32'h0010_0000, 32'hFFFF_FFFF),
                   $urandom_range(32'h0010_0000, 32'hFFFF_FFFF));
        2: set_all(32'hFFFF_FFFF, 32'h0, ONE_Q31, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: set_all(32'h0, 32'hFFFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0);
        4: set_all($urandom, $urandom, $urandom, 32'h0, $urandom, 32'h0);
        5: set_all($urandom, $urandom_range(0, ONE_Q31), $urandom_range(0, ONE_Q31),
                   $urandom_range(0, 1000), $urandom_range(0, 32'h000F_FFFF),
                   $urandom_range(0, 32'h000F_FFFF));
        default: set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      if (p == 7) quiet = 1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_update(pick_value(1), pick_value(1), pick_value(1), pick_value(0));
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("adam_parameter_update_core verification clean");
    end else begin
      $display("adam_parameter_update_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/apu_pkg.sv
sv/apu_sqrt.sv
sv/apu_div.sv
sv/adam_parameter_update_core.sv
sv/apu_checker.sv
bench/adam_parameter_update_core_tb.sv
